@@ rtl/brmd_pkg.sv @@
// Shared constants for the barcode run-length module decoder.
// No dependencies; imported by barcode_run_module_decoder.
package brmd_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 8;
  localparam int IDX_W    = 7;

  // Defaults for the top-level parameters
  localparam int DEF_MODULES  = 67;
  localparam int DEF_RUN_BITS = 14;

  // Reset value of the dark threshold register
  localparam logic [SAMPLE_W-1:0] DEF_THRESHOLD = 8'd128;

  // Most modules emitted for one run
  localparam int MAX_RESULTS = 64;

endpackage

@@ rtl/barcode_run_module_decoder.sv @@
// Barcode run-length module decoder: thresholding, run counting, serial
// ceiling division and module emission. Depends on brmd_pkg.
//
// One scan-line sample is taken per request on the input channel. A sample
// that does not close a run is absorbed directly and the block stays ready
// for the next sample. A sample that closes a counted run starts the shared
// restoring divider, which retires one quotient bit per cycle; the S_CLAMP
// state then clamps the module count, and S_EMIT puts out one module request
// per cycle on the output channel while out_ready lets it: n requests for a
// run worth n modules (n at most 64).
// The input is not ready from the closing sample until the last module of that
// run is loaded into the output register. Samples below dark_threshold (reset
// 128) are dark; the first dark bar sets the module width and is not emitted,
// and decoding stops after MODULES modules until line_start.
module barcode_run_module_decoder #(
  parameter int MODULES  = brmd_pkg::DEF_MODULES,
  parameter int RUN_BITS = brmd_pkg::DEF_RUN_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [brmd_pkg::SAMPLE_W-1:0] cfg_data,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [brmd_pkg::SAMPLE_W-1:0] sample,
  input  logic                          line_start,
  // module channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          module_bit,
  output logic [brmd_pkg::IDX_W-1:0]    module_index,
  output logic                          run_last,
  output logic                          code_done
);
  import brmd_pkg::*;

  localparam int CNT_W = (RUN_BITS > 1) ? $clog2(RUN_BITS) : 1;
  localparam int CMP_W = (RUN_BITS + 1 > IDX_W + 1) ? RUN_BITS + 1 : IDX_W + 1;
  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_REF,
    PH_RUN,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CLAMP,
    S_EMIT
  } seq_t;

  // Registers
  logic [SAMPLE_W-1:0] dark_threshold;
  phase_t              phase;
  logic [RUN_BITS-1:0] run_count;
  logic [RUN_BITS-1:0] reference_width;
  logic                run_colour;
  logic [IDX_W-1:0]    modules_emitted;
  seq_t                seq;
  logic [RUN_BITS-1:0] div_quo;
  logic [RUN_BITS-1:0] div_rem;
  logic [RUN_BITS-1:0] divisor;
  logic [CNT_W-1:0]    div_cnt;
  logic                emit_colour;
  logic [IDX_W-1:0]    emit_left;

  // Accept-time next values
  phase_t              phase_next;
  logic [RUN_BITS-1:0] run_count_next;
  logic [RUN_BITS-1:0] reference_width_next;
  logic                run_colour_next;
  logic                run_end;

  logic                in_acc;
  logic                dark;
  phase_t              ph_c;
  logic [RUN_BITS-1:0] cnt_c;
  logic [RUN_BITS-1:0] ref_c;
  logic                col_c;
  logic [IDX_W-1:0]    emitted_c;
  logic [RUN_BITS-1:0] cnt_inc;

  // Divider step and clamp
  logic [RUN_BITS:0]   rem_sh;
  logic [RUN_BITS:0]   rem_diff;
  logic                rem_ge;
  logic [CMP_W-1:0]    mods_full;
  logic [CMP_W-1:0]    mods_left;
  logic [CMP_W-1:0]    mods_a;
  logic [CMP_W-1:0]    mods_b;
  logic [IDX_W:0]      emitted_inc;
  logic                out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (seq == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign dark      = (sample < dark_threshold);

  // Apply a line restart, then advance the run tracking for this sample
  always_comb begin
    ph_c      = line_start ? PH_SKIP : phase;
    cnt_c     = line_start ? '0 : run_count;
    ref_c     = line_start ? '0 : reference_width;
    col_c     = line_start ? 1'b0 : run_colour;
    emitted_c = line_start ? '0 : modules_emitted;
    cnt_inc   = (cnt_c == RUN_MAX) ? cnt_c : cnt_c + 1'b1;

    phase_next           = ph_c;
    run_count_next       = cnt_c;
    reference_width_next = ref_c;
    run_colour_next      = col_c;
    run_end              = 1'b0;

    unique case (ph_c)
      PH_SKIP: begin
        if (dark) begin
          phase_next     = PH_REF;
          run_count_next = RUN_BITS'(1);
        end
      end
      PH_REF: begin
        if (dark) begin
          run_count_next = cnt_inc;
        end else begin
          reference_width_next = cnt_c;
          run_colour_next      = 1'b0;
          run_count_next       = RUN_BITS'(1);
          phase_next           = PH_RUN;
        end
      end
      PH_RUN: begin
        if (dark == col_c) begin
          run_count_next = cnt_inc;
        end else begin
          run_end         = 1'b1;
          run_colour_next = dark;
          run_count_next  = RUN_BITS'(1);
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // One restoring division step: shift in the next dividend bit, try subtract
  always_comb begin
    rem_sh   = {div_rem, div_quo[RUN_BITS-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    rem_ge   = (rem_sh >= {1'b0, divisor});
  end

  // Round the quotient up, then clamp to what is left of the code and to 64
  always_comb begin
    mods_full = CMP_W'(div_quo) + CMP_W'(div_rem != '0);
    mods_left = CMP_W'(MODULES) - CMP_W'(modules_emitted);
    mods_a    = (mods_full < mods_left) ? mods_full : mods_left;
    mods_b    = (mods_a < CMP_W'(MAX_RESULTS)) ? mods_a : CMP_W'(MAX_RESULTS);
  end

  assign emitted_inc = {1'b0, modules_emitted} + 1'b1;
  assign out_load    = (seq == S_EMIT) && (!out_valid || out_ready);

  // Sequencer, decoder state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dark_threshold  <= DEF_THRESHOLD;
      phase           <= PH_SKIP;
      run_count       <= '0;
      reference_width <= '0;
      run_colour      <= 1'b0;
      modules_emitted <= '0;
      seq             <= S_IDLE;
      out_valid       <= 1'b0;
      div_cnt         <= '0;
      emit_left       <= '0;
    end else begin
      // take a threshold write
      if (cfg_valid && cfg_ready) begin
        dark_threshold <= cfg_data;
      end

      // drop a delivered module request unless the next one replaces it
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (seq)
        S_IDLE: begin
          if (in_acc) begin
            phase           <= phase_next;
            run_count       <= run_count_next;
            reference_width <= reference_width_next;
            run_colour      <= run_colour_next;
            modules_emitted <= emitted_c;
            if (run_end) begin
              div_quo     <= cnt_c;
              div_rem     <= '0;
              divisor     <= (ref_c == '0) ? RUN_BITS'(1) : ref_c;
              div_cnt     <= '0;
              emit_colour <= col_c;
              seq         <= S_DIV;
            end
          end
        end
        S_DIV: begin
          div_rem <= rem_ge ? rem_diff[RUN_BITS-1:0] : rem_sh[RUN_BITS-1:0];
          div_quo <= {div_quo[RUN_BITS-2:0], rem_ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CNT_W'(RUN_BITS - 1)) begin
            seq <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          emit_left <= mods_b[IDX_W-1:0];
          seq       <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid       <= 1'b1;
            module_bit      <= emit_colour;
            module_index    <= modules_emitted;
            run_last        <= (emit_left == IDX_W'(1));
            code_done       <= (emitted_inc == (IDX_W+1)'(MODULES));
            modules_emitted <= emitted_inc[IDX_W-1:0];
            emit_left       <= emit_left - 1'b1;
            if (emit_left == IDX_W'(1)) begin
              seq <= S_IDLE;
              if (emitted_inc >= (IDX_W+1)'(MODULES)) begin
                phase <= PH_DONE;
              end
            end
          end
        end
        default: begin
          seq <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Emitted positions never run past the end of the code
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (IDX_W+1)'(module_index) < (IDX_W+1)'(MODULES))
    else $error("module index beyond code length");

  // Code completion flag is raised only on the final position
  a_done_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && code_done) |-> (IDX_W+1)'(module_index) == (IDX_W+1)'(MODULES - 1))
    else $error("code_done on wrong module");

  // Per-run emission count stays within the clamp
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (seq == S_EMIT) |-> (emit_left != '0 && emit_left <= IDX_W'(MAX_RESULTS)))
    else $error("emission count out of range");

  // A finished code has emitted all its modules once idle
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    (seq == S_IDLE && phase == PH_DONE) |->
      (IDX_W+1)'(modules_emitted) >= (IDX_W+1)'(MODULES))
    else $error("code marked complete too early");
`endif

endmodule

@@ bench/barcode_run_module_decoder_tb.sv @@
// Self-checking bench for barcode_run_module_decoder: scan-line samples in,
// decoded modules out, checked against an in-bench line decoder.
// Depends on brmd_pkg and the decoder RTL only.
module barcode_run_module_decoder_tb;

  localparam int SAMPLE_W      = brmd_pkg::SAMPLE_W;
  localparam int MODULES       = brmd_pkg::DEF_MODULES;
  localparam int RUN_BITS      = brmd_pkg::DEF_RUN_BITS;
  localparam int RUN_MAX       = (1 << RUN_BITS) - 1;
  localparam int IDLE_PCT      = 27;
  localparam int SETTLE_CYCLES = RUN_BITS + brmd_pkg::MAX_RESULTS + 8;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum logic [1:0] {
    SKIP_LIGHT, MEASURE_REF, COUNT_RUNS, CODE_COMPLETE
  } line_phase_t;

  typedef struct packed {
    logic [brmd_pkg::SAMPLE_W-1:0] value;
    logic                          restart;
  } scan_item_t;

  typedef struct packed {
    logic                       dark_bar;
    logic [brmd_pkg::IDX_W-1:0] index;
    logic                       last_of_run;
    logic                       final_module;
  } module_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [brmd_pkg::SAMPLE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [brmd_pkg::SAMPLE_W-1:0] sample = '0;
  logic line_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic module_bit;
  logic [brmd_pkg::IDX_W-1:0] module_index;
  logic run_last;
  logic code_done;

  // Pending requests and decoded modules still owed by the block
  scan_item_t scan_q[$];
  logic [brmd_pkg::SAMPLE_W-1:0] threshold_q[$];
  module_rec_t modules_expected[$];

  int items_pushed = 0;
  int failures = 0;
  int cycle_count = 0;
  int gen_thr = int'(brmd_pkg::DEF_THRESHOLD);
  logic no_stall = 1'b0;

  // Line decoder state
  logic [brmd_pkg::SAMPLE_W-1:0] threshold_model = brmd_pkg::DEF_THRESHOLD;
  line_phase_t                   line_phase = SKIP_LIGHT;
  logic [RUN_BITS-1:0]           run_len = '0;
  logic [RUN_BITS-1:0]           module_width = '0;
  logic                          run_dark = 1'b0;
  logic [brmd_pkg::IDX_W-1:0]    emitted = '0;

  barcode_run_module_decoder #(
    .MODULES (MODULES),
    .RUN_BITS(RUN_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .line_start  (line_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .module_bit  (module_bit),
    .module_index(module_index),
    .run_last    (run_last),
    .code_done   (code_done)
  );

  always #1 clk = ~clk;

  // Advance the line decoder by one accepted sample
  task automatic decode_sample(input logic [brmd_pkg::SAMPLE_W-1:0] value,
                               input logic restart);
    logic dark;
    int unsigned divisor, count, room, k;
    module_rec_t rec;
    dark = (value < threshold_model);
    if (restart) begin
      line_phase   = SKIP_LIGHT;
      run_len      = '0;
      module_width = '0;
      run_dark     = 1'b0;
      emitted      = '0;
    end
    case (line_phase)
      SKIP_LIGHT: begin
        if (dark) begin
          line_phase = MEASURE_REF;
          run_len    = RUN_BITS'(1);
        end
      end
      MEASURE_REF: begin
        if (dark) begin
          if (run_len != RUN_MAX) run_len = run_len + 1'b1;
        end else begin
          module_width = run_len;
          run_dark     = 1'b0;
          run_len      = RUN_BITS'(1);
          line_phase   = COUNT_RUNS;
        end
      end
      COUNT_RUNS: begin
        if (dark == run_dark) begin
          if (run_len != RUN_MAX) run_len = run_len + 1'b1;
        end else begin
          // Close the run: round up to whole modules, clip to what is left
          divisor = (module_width == 0) ? 1 : module_width;
          count   = (run_len + divisor - 1) / divisor;
          room    = (emitted < MODULES) ? MODULES - emitted : 0;
          if (count > room) count = room;
          if (count > brmd_pkg::MAX_RESULTS) count = brmd_pkg::MAX_RESULTS;
          for (k = 0; k < count; k++) begin
            rec.dark_bar     = run_dark;
            rec.index        = emitted;
            rec.last_of_run  = (k + 1 == count);
            rec.final_module = (emitted + 1 == MODULES);
            modules_expected.push_back(rec);
            emitted = emitted + 1'b1;
          end
          run_dark = dark;
          run_len  = RUN_BITS'(1);
          if (emitted >= MODULES) line_phase = CODE_COMPLETE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [brmd_pkg::SAMPLE_W-1:0] value,
                           input logic restart);
    scan_item_t it;
    it.value   = value;
    it.restart = restart;
    scan_q.push_back(it);
    items_pushed++;
  endtask

  function automatic logic [brmd_pkg::SAMPLE_W-1:0] pick_sample(input logic want_dark);
    if (want_dark && gen_thr > 0) return SAMPLE_W'($urandom_range(gen_thr - 1, 0));
    return SAMPLE_W'($urandom_range(255, gen_thr));
  endfunction

  // Wait for the block to drain, then let any internal work finish
  task automatic settle();
    do @(negedge clk);
    while (scan_q.size() != 0 || in_valid || threshold_q.size() != 0 || cfg_valid ||
           modules_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [brmd_pkg::SAMPLE_W-1:0] value);
    settle();
    threshold_q.push_back(value);
    gen_thr = int'(value);
    do @(negedge clk);
    while (threshold_q.size() != 0 || cfg_valid);
  endtask

  // Mostly well-formed lines with jittered run lengths, some noise bursts
  task automatic random_lines(input int budget);
    int start, w, runs, mods, len, r, i;
    logic colour;
    start = items_pushed;
    while (items_pushed - start < budget) begin
      if (gen_thr == 0 || $urandom_range(99) < 15) begin
        repeat ($urandom_range(15, 5))
          push_item(SAMPLE_W'($urandom_range(255, 0)), $urandom_range(5, 0) == 0);
      end else begin
        push_item(pick_sample(1'b0), 1'b1);
        repeat ($urandom_range(3, 0)) push_item(pick_sample(1'b0), 1'b0);
        w = $urandom_range(3, 1);
        repeat (w) push_item(pick_sample(1'b1), 1'b0);
        colour = 1'b0;
        runs = $urandom_range(30, 1);
        for (r = 0; r < runs && items_pushed - start < budget; r++) begin
          mods = $urandom_range(5, 1);
          len  = mods * w - $urandom_range(w - 1, 0);
          for (i = 0; i < len && items_pushed - start < budget; i++) begin
            if ($urandom_range(99) < 3)
              push_item(SAMPLE_W'($urandom_range(255, 0)), $urandom_range(9, 0) == 0);
            else
              push_item(pick_sample(colour), 1'b0);
          end
          colour = ~colour;
        end
      end
    end
  endtask

  // Drive threshold writes and sample requests
  always @(posedge clk) begin : drive_requests
    scan_item_t nxt;
    if (rst) begin
      cfg_valid <= 1'b0;
      in_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) threshold_model = cfg_data;
      if (!cfg_valid || cfg_ready) begin
        if (threshold_q.size() > 0) begin
          cfg_data  <= threshold_q.pop_front();
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
      if (in_valid && in_ready) decode_sample(sample, line_start);
      if (!in_valid || in_ready) begin
        if (scan_q.size() > 0 && (no_stall || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = scan_q.pop_front();
          sample     <= nxt.value;
          line_start <= nxt.restart;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each accepted module against the oldest one owed
  always @(posedge clk) begin : check_modules
    module_rec_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (modules_expected.size() == 0) begin
          $error("module %0d delivered with none outstanding", module_index);
          failures++;
        end else begin
          want = modules_expected.pop_front();
          if (module_bit !== want.dark_bar) begin
            $error("module_bit mismatch: expected %0d, got %0d", want.dark_bar, module_bit);
            failures++;
          end
          if (module_index !== want.index) begin
            $error("module_index mismatch: expected %0d, got %0d", want.index, module_index);
            failures++;
          end
          if (run_last !== want.last_of_run) begin
            $error("run_last mismatch: expected %0d, got %0d", want.last_of_run, run_last);
            failures++;
          end
          if (code_done !== want.final_module) begin
            $error("code_done mismatch: expected %0d, got %0d", want.final_module, code_done);
            failures++;
          end
        end
      end
      out_ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Threshold boundary, reference of two, rounding up, restart mid-run
    push_item(8'd200, 1'b1);
    push_item(8'd128, 1'b0);
    push_item(8'd127, 1'b0);
    push_item(8'd0,   1'b0);
    push_item(8'd255, 1'b0);
    push_item(8'd130, 1'b0);
    push_item(8'd140, 1'b0);
    push_item(8'd10,  1'b0);
    push_item(8'd20,  1'b0);
    push_item(8'd200, 1'b0);
    push_item(8'd250, 1'b0);
    push_item(8'd100, 1'b1);
    push_item(8'd255, 1'b0);
    push_item(8'd0,   1'b0);
    push_item(8'd255, 1'b0);
    repeat (4) push_item(8'd0, 1'b0);
    push_item(8'd255, 1'b0);
    push_item(8'd0,   1'b0);
    push_item(8'd200, 1'b1);

    // Long light run capped at a full burst, then code complete
    settle();
    push_item(8'd200, 1'b1);
    push_item(8'd5,   1'b0);
    repeat (70) push_item(8'd200, 1'b0);
    repeat (2) push_item(8'd5, 1'b0);
    push_item(8'd200, 1'b0);
    push_item(8'd5,   1'b0);
    push_item(8'd200, 1'b0);
    push_item(8'd5,   1'b0);

    // Wide reference bar, then an unterminated run at line end
    push_item(8'd5, 1'b1);
    repeat (3) push_item(8'd5, 1'b0);
    repeat (3) push_item(8'd200, 1'b0);
    push_item(8'd5, 1'b0);
    repeat (2) push_item(8'd200, 1'b0);

    write_threshold(8'd255);
    random_lines(12);
    write_threshold(8'd0);
    random_lines(5);
    write_threshold(8'd1);
    random_lines(12);
    write_threshold(SAMPLE_W'($urandom_range(254, 2)));
    no_stall = 1'b1;
    random_lines(20);
    settle();
    no_stall = 1'b0;
    write_threshold(brmd_pkg::DEF_THRESHOLD);
    random_lines(12);

    settle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
